### src/tdor_pkg.sv
// Shared types and constants for the torus dimension-order router.
// Holds the configuration, controller command and datapath status structs.
// Depends on nothing; every other file of the block uses it.
package tdor_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_DIMS_DEF     = 4;
  localparam int MAX_DIM_SIZE_DEF = 16;

  // Field and internal widths.
  localparam int NODE_W        = 16;  // node rank
  localparam int RANK_W        = 17;  // rank while routing, can pass 16 bits above the torus
  localparam int LINK_W        = 19;  // link table index
  localparam int OFF_W         = 20;  // node offset before truncation
  localparam int LPN_W         = 3;   // links per node
  localparam int NDIM_W        = 3;   // number of dimensions register
  localparam int SIZE_W        = 5;   // dimension size register
  localparam int NUM_SIZE_REGS = 4;   // dimension size registers in the map

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_3     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOOPBACK_ON    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIMITER_ON     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LINKS_PER_NODE = 3'd7;

  // Configuration register file contents.
  typedef struct packed {
    logic [NDIM_W-1:0]                    num_dims;
    logic [NUM_SIZE_REGS-1:0][SIZE_W-1:0] dim_size;
    logic                                 loopback_on;
    logic                                 limiter_on;
    logic [LPN_W-1:0]                     links_per_node;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;      // latch a new request
    logic load_loop;  // load the loopback result
    logic div_step;   // one restoring division step on both ranks
    logic div_store;  // keep coordinates and strides of the current dimension
    logic dim_clear;  // back to dimension 0
    logic dim_inc;    // next dimension
    logic dim_init;   // start walking the current dimension
    logic hop_calc;   // work out the next coordinate and rank
    logic off_calc;   // work out the node offset of the hop
    logic load_lim;   // load the limiter result
    logic load_link;  // load the link result
    logic advance;    // move to the next node
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_router;    // request involves a router
    logic in_same;      // source equals destination
    logic loopback_on;
    logic limiter_on;
    logic dim_is_last;  // current dimension is the last one in use
    logic dim_differs;  // source and target coordinates differ here
    logic hop_done;     // the pending hop reaches the target coordinate
    logic out_lim;      // held result is a limiter entry
    logic out_last;     // held result ends the route
  } sts_t;

endpackage

### src/tdor_ctrl.sv
// Controller state machine of the torus dimension-order router.
// Sequences division, dimension walk, hop computation and result handoff.
// Depends on tdor_pkg for the command and status structs.
module tdor_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  tdor_pkg::sts_t sts,
  output tdor_pkg::cmd_t cmd
);

  localparam int CNT_W = $clog2(tdor_pkg::NODE_W);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_STORE = 4'd2;
  localparam logic [3:0] S_SEL   = 4'd3;
  localparam logic [3:0] S_HOP   = 4'd4;
  localparam logic [3:0] S_OFF   = 4'd5;
  localparam logic [3:0] S_LIM   = 4'd6;
  localparam logic [3:0] S_LINK  = 4'd7;
  localparam logic [3:0] S_SEND  = 4'd8;

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  // State and division bit counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_SEND);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          if (sts.in_router) begin
            state_next = S_IDLE;
          end else if (sts.in_same) begin
            if (sts.loopback_on) begin
              cmd.load_loop = 1'b1;
              state_next    = S_SEND;
            end
          end else begin
            cnt_next   = '0;
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == '1) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.div_store = 1'b1;
        if (sts.dim_is_last) begin
          cmd.dim_clear = 1'b1;
          state_next    = S_SEL;
        end else begin
          cmd.dim_inc = 1'b1;
          state_next  = S_DIV;
        end
      end
      S_SEL: begin
        // Skip dimensions that already match; stop after the last one.
        if (sts.dim_differs) begin
          cmd.dim_init = 1'b1;
          state_next   = S_HOP;
        end else if (sts.dim_is_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.dim_inc = 1'b1;
        end
      end
      S_HOP: begin
        cmd.hop_calc = 1'b1;
        state_next   = S_OFF;
      end
      S_OFF: begin
        cmd.off_calc = 1'b1;
        state_next   = sts.limiter_on ? S_LIM : S_LINK;
      end
      S_LIM: begin
        cmd.load_lim = 1'b1;
        state_next   = S_SEND;
      end
      S_LINK: begin
        cmd.load_link = 1'b1;
        state_next    = S_SEND;
      end
      S_SEND: begin
        if (out_ready) begin
          if (sts.out_lim) begin
            state_next = S_LINK;
          end else if (sts.out_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            if (sts.hop_done) begin
              cmd.dim_inc = 1'b1;
              state_next  = S_SEL;
            end else begin
              state_next = S_HOP;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### src/tdor_dp.sv
// Datapath of the torus dimension-order router.
// Serial coordinate division, strides, hop arithmetic and the result register.
// Depends on tdor_pkg; driven by tdor_ctrl through the command struct.
module tdor_dp #(
  parameter int MAX_DIMS     = tdor_pkg::MAX_DIMS_DEF,
  parameter int MAX_DIM_SIZE = tdor_pkg::MAX_DIM_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tdor_pkg::cfg_t                cfg,
  input  tdor_pkg::cmd_t                cmd,
  input  logic [tdor_pkg::NODE_W-1:0]   src_node,
  input  logic [tdor_pkg::NODE_W-1:0]   dst_node,
  input  logic                          src_router,
  input  logic                          dst_router,
  output tdor_pkg::sts_t                sts,
  output logic [tdor_pkg::LINK_W-1:0]   link_index,
  output logic                          use_up,
  output logic                          limiter_entry,
  output logic [tdor_pkg::NODE_W-1:0]   hop_node,
  output logic                          last
);

  localparam int NODE_W = tdor_pkg::NODE_W;
  localparam int RANK_W = tdor_pkg::RANK_W;
  localparam int LINK_W = tdor_pkg::LINK_W;
  localparam int OFF_W  = tdor_pkg::OFF_W;
  localparam int NDIM_W = tdor_pkg::NDIM_W;
  localparam int SIZE_W = tdor_pkg::SIZE_W;
  localparam int DW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CW     = $clog2(MAX_DIM_SIZE);  // coordinate
  localparam int SW     = CW + 1;                // dimension size
  localparam int SW1    = SW + 1;                // direction arithmetic
  localparam int PW     = RANK_W + SW;           // stride product

  // Effective configuration, out-of-range values clamped.
  logic [NDIM_W-1:0] nd_eff;
  logic [DW-1:0]     nd_last;
  logic [SW-1:0]     sz [MAX_DIMS];

  always_comb begin
    if (cfg.num_dims == '0) begin
      nd_eff = NDIM_W'(1);
    end else if (cfg.num_dims > NDIM_W'(MAX_DIMS)) begin
      nd_eff = NDIM_W'(MAX_DIMS);
    end else begin
      nd_eff = cfg.num_dims;
    end
    nd_last = DW'(nd_eff - NDIM_W'(1));
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (cfg.dim_size[i] == '0) begin
        sz[i] = SW'(1);
      end else if (cfg.dim_size[i] > SIZE_W'(MAX_DIM_SIZE)) begin
        sz[i] = SW'(MAX_DIM_SIZE);
      end else begin
        sz[i] = SW'(cfg.dim_size[i]);
      end
    end
  end

  // Request and routing registers.
  logic [DW-1:0]     dim;
  logic [NODE_W-1:0] q_src, q_dst;
  logic [CW-1:0]     rem_src, rem_dst;
  logic [RANK_W-1:0] prod;
  logic [CW-1:0]     sc [MAX_DIMS];
  logic [CW-1:0]     dc [MAX_DIMS];
  logic [RANK_W-1:0] stride [MAX_DIMS];
  logic [RANK_W-1:0] span [MAX_DIMS];
  logic [CW-1:0]     cur, nc;
  logic              right;
  logic [RANK_W-1:0] cur_rank, nrank;
  logic [OFF_W-1:0]  off;

  // Restoring division step on both ranks by the current dimension size.
  logic [SW-1:0] dsz, sh_src, sh_dst, df_src, df_dst;
  logic          ge_src, ge_dst;

  assign dsz    = sz[dim];
  assign sh_src = {rem_src, q_src[NODE_W-1]};
  assign sh_dst = {rem_dst, q_dst[NODE_W-1]};
  assign df_src = sh_src - dsz;
  assign df_dst = sh_dst - dsz;
  assign ge_src = (sh_src >= dsz);
  assign ge_dst = (sh_dst >= dsz);

  // Stride of the next dimension and the span of a wrap in this one.
  logic [PW-1:0]     prod_w;
  logic [RANK_W-1:0] prod_mul;

  assign prod_w   = PW'(prod) * PW'(dsz);
  assign prod_mul = prod_w[RANK_W-1:0];

  // Direction in the current dimension, with wrap-around.
  logic [SW1-1:0] s_w, t_w, m_w, half_w, sum_w, wrap_w;
  logic           dir_right;

  always_comb begin
    s_w       = SW1'(sc[dim]);
    t_w       = SW1'(dc[dim]);
    m_w       = SW1'(dsz);
    half_w    = m_w >> 1;
    sum_w     = s_w + half_w;
    wrap_w    = (sum_w >= m_w) ? (sum_w - m_w) : sum_w;
    dir_right = ((t_w > s_w) && (t_w <= sum_w)) || ((s_w > half_w) && (wrap_w >= t_w));
  end

  // Highest coordinate of the current dimension.
  logic [SW-1:0] m1_w;
  logic [CW-1:0] m1;

  assign m1_w = dsz - SW'(1);
  assign m1   = m1_w[CW-1:0];

  // Node offset and result link sums.
  logic [RANK_W-1:0] rank_sel;
  logic [OFF_W-1:0]  off_prod, lim_sum, link_sum;
  logic [LINK_W-1:0] loop_prod;

  assign rank_sel  = right ? cur_rank : nrank;
  assign off_prod  = OFF_W'(rank_sel) * OFF_W'(cfg.links_per_node);
  assign lim_sum   = off + OFF_W'(cfg.loopback_on);
  assign link_sum  = off + OFF_W'(cfg.loopback_on) + OFF_W'(cfg.limiter_on) + OFF_W'(dim);
  assign loop_prod = LINK_W'(src_node) * LINK_W'(cfg.links_per_node);

  // Any dimension after the current one still to be walked.
  logic later_diff;

  always_comb begin
    later_diff = 1'b0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      if ((NDIM_W'(i) < nd_eff) && (DW'(i) > dim) && (sc[i] != dc[i])) begin
        later_diff = 1'b1;
      end
    end
  end

  // Dimension index.
  always_ff @(posedge clk) begin
    if (rst) begin
      dim <= '0;
    end else if (cmd.start || cmd.dim_clear) begin
      dim <= '0;
    end else if (cmd.dim_inc) begin
      dim <= dim + DW'(1);
    end
  end

  // Division, coordinates and strides.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_src   <= src_node;
      q_dst   <= dst_node;
      rem_src <= '0;
      rem_dst <= '0;
      prod    <= RANK_W'(1);
    end else if (cmd.div_step) begin
      q_src   <= {q_src[NODE_W-2:0], ge_src};
      q_dst   <= {q_dst[NODE_W-2:0], ge_dst};
      rem_src <= ge_src ? df_src[CW-1:0] : sh_src[CW-1:0];
      rem_dst <= ge_dst ? df_dst[CW-1:0] : sh_dst[CW-1:0];
    end else if (cmd.div_store) begin
      sc[dim]     <= rem_src;
      dc[dim]     <= rem_dst;
      stride[dim] <= prod;
      span[dim]   <= prod_mul - prod;
      prod        <= prod_mul;
      rem_src     <= '0;
      rem_dst     <= '0;
    end
  end

  // Walk through the current dimension one hop at a time.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_rank <= RANK_W'(src_node);
    end else if (cmd.dim_init) begin
      cur   <= sc[dim];
      right <= dir_right;
    end else if (cmd.hop_calc) begin
      if (right) begin
        if (cur == m1) begin
          nc    <= '0;
          nrank <= cur_rank - span[dim];
        end else begin
          nc    <= cur + CW'(1);
          nrank <= cur_rank + stride[dim];
        end
      end else begin
        if (cur == '0) begin
          nc    <= m1;
          nrank <= cur_rank + span[dim];
        end else begin
          nc    <= cur - CW'(1);
          nrank <= cur_rank - stride[dim];
        end
      end
    end else if (cmd.off_calc) begin
      off <= off_prod;
    end else if (cmd.advance) begin
      cur      <= nc;
      cur_rank <= nrank;
    end
  end

  // Result register, held until the result is taken.
  always_ff @(posedge clk) begin
    if (cmd.load_loop) begin
      link_index    <= loop_prod;
      use_up        <= 1'b1;
      limiter_entry <= 1'b0;
      hop_node      <= src_node;
      last          <= 1'b1;
    end else if (cmd.load_lim) begin
      link_index    <= lim_sum[LINK_W-1:0];
      use_up        <= 1'b1;
      limiter_entry <= 1'b1;
      hop_node      <= nrank[NODE_W-1:0];
      last          <= 1'b0;
    end else if (cmd.load_link) begin
      link_index    <= link_sum[LINK_W-1:0];
      use_up        <= right;
      limiter_entry <= 1'b0;
      hop_node      <= nrank[NODE_W-1:0];
      last          <= (nc == dc[dim]) && !later_diff;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.in_router   = src_router | dst_router;
    sts.in_same     = (src_node == dst_node);
    sts.loopback_on = cfg.loopback_on;
    sts.limiter_on  = cfg.limiter_on;
    sts.dim_is_last = (dim == nd_last);
    sts.dim_differs = (sc[dim] != dc[dim]);
    sts.hop_done    = (nc == dc[dim]);
    sts.out_lim     = limiter_entry;
    sts.out_last    = last;
  end

endmodule

### src/torus_dimension_order_router_unit.sv
// Torus dimension-order router: one route request in, a run of link entries out.
// The serial coordinate division runs once per dimension in use, then the dimensions are
// scanned and each hop is computed, its limiter entry first when enabled, and held until
// taken; a loopback answer is loaded straight from the request. One request at a time.
// Reset (rst, synchronous) idles the controller and restores register defaults.
module torus_dimension_order_router_unit #(
  parameter int MAX_DIMS     = tdor_pkg::MAX_DIMS_DEF,
  parameter int MAX_DIM_SIZE = tdor_pkg::MAX_DIM_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Route requests.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [31:0]                        s_tdata,   // src_node, dst_node
  input  logic [1:0]                         s_tuser,   // src_router, dst_router
  // Route results.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [39:0]                        m_tdata,   // link_index, hop_node
  output logic [1:0]                         m_tuser,   // use_up, limiter_entry
  output logic                               m_tlast,
  // Register writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tdor_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tdor_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int NODE_W = tdor_pkg::NODE_W;
  localparam int LINK_W = tdor_pkg::LINK_W;
  localparam int PAD_W  = 40 - LINK_W - NODE_W;

  tdor_pkg::cfg_t cfg;
  tdor_pkg::cmd_t cmd;
  tdor_pkg::sts_t sts;

  logic [LINK_W-1:0] link_index;
  logic [NODE_W-1:0] hop_node;
  logic              use_up, limiter_entry, last;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_dims       <= tdor_pkg::NDIM_W'(1);
      cfg.dim_size       <= {tdor_pkg::NUM_SIZE_REGS{tdor_pkg::SIZE_W'(1)}};
      cfg.loopback_on    <= 1'b0;
      cfg.limiter_on     <= 1'b0;
      cfg.links_per_node <= tdor_pkg::LPN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tdor_pkg::REG_NUM_DIMS:       cfg.num_dims <= cfg_data[tdor_pkg::NDIM_W-1:0];
        tdor_pkg::REG_DIM_SIZE_0:     cfg.dim_size[0] <= cfg_data[tdor_pkg::SIZE_W-1:0];
        tdor_pkg::REG_DIM_SIZE_1:     cfg.dim_size[1] <= cfg_data[tdor_pkg::SIZE_W-1:0];
        tdor_pkg::REG_DIM_SIZE_2:     cfg.dim_size[2] <= cfg_data[tdor_pkg::SIZE_W-1:0];
        tdor_pkg::REG_DIM_SIZE_3:     cfg.dim_size[3] <= cfg_data[tdor_pkg::SIZE_W-1:0];
        tdor_pkg::REG_LOOPBACK_ON:    cfg.loopback_on <= cfg_data[0];
        tdor_pkg::REG_LIMITER_ON:     cfg.limiter_on <= cfg_data[0];
        tdor_pkg::REG_LINKS_PER_NODE: cfg.links_per_node <= cfg_data[tdor_pkg::LPN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Controller.
  tdor_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath.
  tdor_dp #(
    .MAX_DIMS     (MAX_DIMS),
    .MAX_DIM_SIZE (MAX_DIM_SIZE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .src_node      (s_tdata[15:0]),
    .dst_node      (s_tdata[31:16]),
    .src_router    (s_tuser[0]),
    .dst_router    (s_tuser[1]),
    .sts           (sts),
    .link_index    (link_index),
    .use_up        (use_up),
    .limiter_entry (limiter_entry),
    .hop_node      (hop_node),
    .last          (last)
  );

  // Result packing.
  assign m_tdata = {{PAD_W{1'b0}}, hop_node, link_index};
  assign m_tuser = {limiter_entry, use_up};
  assign m_tlast = last;

  // A result on offer means no new request is being taken.
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("request taken while a result is pending");

  // The last result of a route frees the block for the next request.
  a_free_after_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("block not ready after the last result");

  // A limiter entry never ends a route.
  a_lim_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> !m_tlast)
    else $error("limiter entry marked last");

  // A limiter entry is followed by its link entry, loaded in the next cycle.
  a_lim_then_link: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser[1]) |=> (!m_tvalid ##1 (m_tvalid && !m_tuser[1])))
    else $error("limiter entry not followed by its link entry");

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for torus_dimension_order_router_unit: route requests go in,
// link entries come out, and each entry is checked against a behavioral route predictor.
// Depends on tdor_pkg and the router RTL.
module tb;

  localparam int NODE_W           = tdor_pkg::NODE_W;
  localparam int LINK_W           = tdor_pkg::LINK_W;
  localparam int NDIM_W           = tdor_pkg::NDIM_W;
  localparam int LPN_W            = tdor_pkg::LPN_W;
  localparam int NUM_SIZE_REGS    = tdor_pkg::NUM_SIZE_REGS;
  localparam int CFG_IDX_W        = tdor_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W       = tdor_pkg::CFG_DATA_W;
  localparam int MAX_DIMS_DEF     = tdor_pkg::MAX_DIMS_DEF;
  localparam int MAX_DIM_SIZE_DEF = tdor_pkg::MAX_DIM_SIZE_DEF;

  localparam int IDLE_PCT         = 29;
  localparam int DRAIN_CYCLES     = 120;   // covers division and scan of a request with no entries
  localparam int STALL_LIMIT      = 2000;
  localparam int RANDOM_PHASES    = 6;
  localparam int ROUTES_PER_PHASE = 40;
  localparam int CALM_PHASE       = 2;
  localparam int MAX_ROUTE        = 64;

  typedef struct packed {
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
    logic              src_router;
    logic              dst_router;
  } route_req_t;

  typedef struct packed {
    logic [LINK_W-1:0] link_index;
    logic              use_up;
    logic              limiter_entry;
    logic [NODE_W-1:0] hop_node;
    logic              last;
  } hop_entry_t;

  // One row of the directed plan: either a full register setup or a single request.
  typedef struct packed {
    logic                        setup;
    logic [7:0][CFG_DATA_W-1:0]  regs;
    route_req_t                  req;
    logic                        typed;      // expectation written in the row
    logic                        typed_hit;  // typed row yields one entry
    hop_entry_t                  typed_hop;
  } plan_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata = '0;    // src_node, dst_node
  logic [1:0]            s_tuser = '0;    // src_router, dst_router
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [39:0]           m_tdata;         // link_index, hop_node
  logic [1:0]            m_tuser;         // use_up, limiter_entry
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register copy used by the predictor, at reset values.
  int unsigned torus_dims  = 1;
  int unsigned torus_size [NUM_SIZE_REGS] = '{1, 1, 1, 1};
  int unsigned loop_on     = 0;
  int unsigned lim_on      = 0;
  int unsigned link_stride = 1;

  hop_entry_t  pending_hops [$];
  hop_entry_t  held_hop;
  logic        held_valid;
  int unsigned held_count;
  plan_row_t   plan [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  logic        calm = 1'b0;

  torus_dimension_order_router_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Append one expected entry at the tail of the scoreboard.
  function automatic void queue_hop(input hop_entry_t h);
    pending_hops.insert(pending_hops.size(), h);
  endfunction

  // Append one row at the tail of the directed plan.
  function automatic void queue_row(input plan_row_t row);
    plan.insert(plan.size(), row);
  endfunction

  // Route prediction. The newest entry is held back so that the final one can carry last.
  function automatic void stage_hop(input int unsigned link, input logic up, input logic lim,
                                    input int unsigned node);
    if (held_count >= MAX_ROUTE) return;
    if (held_valid) queue_hop(held_hop);
    held_hop.link_index    = link[LINK_W-1:0];
    held_hop.use_up        = up;
    held_hop.limiter_entry = lim;
    held_hop.hop_node      = node[NODE_W-1:0];
    held_hop.last          = 1'b0;
    held_valid = 1'b1;
    held_count++;
  endfunction

  function automatic void predict_route(input route_req_t rq);
    int unsigned src, dst, nd, prod, base, m, s, t, cur_rank, next_rank, nc, off;
    int unsigned sz [MAX_DIMS_DEF];
    int unsigned stride [MAX_DIMS_DEF];
    int unsigned sc [MAX_DIMS_DEF];
    int unsigned dc [MAX_DIMS_DEF];
    int unsigned cur [MAX_DIMS_DEF];
    logic right;
    src = rq.src_node;
    dst = rq.dst_node;
    held_valid = 1'b0;
    held_count = 0;
    if (rq.src_router || rq.dst_router) begin
      // A router on either end never gets a route.
    end else if (src == dst) begin
      if (loop_on != 0) stage_hop(src * link_stride, 1'b1, 1'b0, src);
    end else begin
      nd = torus_dims;
      if (nd < 1) nd = 1;
      if (nd > MAX_DIMS_DEF) nd = MAX_DIMS_DEF;
      prod = 1;
      for (int i = 0; i < nd; i++) begin
        sz[i] = torus_size[i];
        if (sz[i] < 1) sz[i] = 1;
        if (sz[i] > MAX_DIM_SIZE_DEF) sz[i] = MAX_DIM_SIZE_DEF;
        stride[i] = prod;
        sc[i] = (src / prod) % sz[i];
        dc[i] = (dst / prod) % sz[i];
        cur[i] = sc[i];
        prod = prod * sz[i];
      end
      // Bits of the rank above the torus ride along unchanged.
      base = (src / prod) * prod;
      for (int j = 0; j < nd; j++) begin
        m = sz[j];
        s = sc[j];
        t = dc[j];
        right = (t > s && t <= s + m / 2) || (s > m / 2 && (s + m / 2) % m >= t);
        while (cur[j] != t && held_count < MAX_ROUTE) begin
          cur_rank = base;
          for (int i = 0; i < nd; i++) cur_rank = cur_rank + cur[i] * stride[i];
          nc = right ? (cur[j] + 1) % m : (cur[j] + m - 1) % m;
          next_rank = cur_rank - cur[j] * stride[j] + nc * stride[j];
          // Going right uses our own link upward; going left uses the neighbor's downward.
          off = (right ? cur_rank : next_rank) * link_stride + loop_on;
          if (lim_on != 0) stage_hop(off, 1'b1, 1'b1, next_rank);
          stage_hop(off + lim_on + j, right, 1'b0, next_rank);
          cur[j] = nc;
        end
      end
    end
    if (held_valid) begin
      held_hop.last = 1'b1;
      queue_hop(held_hop);
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Directed plan builders.
  function automatic void add_setup(input int unsigned nd, input int unsigned s0,
                                    input int unsigned s1, input int unsigned s2,
                                    input int unsigned s3, input int unsigned lb,
                                    input int unsigned lm, input int unsigned lpn);
    plan_row_t row;
    row = '0;
    row.setup = 1'b1;
    row.regs[tdor_pkg::REG_NUM_DIMS]       = nd[CFG_DATA_W-1:0];
    row.regs[tdor_pkg::REG_DIM_SIZE_0]     = s0[CFG_DATA_W-1:0];
    row.regs[tdor_pkg::REG_DIM_SIZE_1]     = s1[CFG_DATA_W-1:0];
    row.regs[tdor_pkg::REG_DIM_SIZE_2]     = s2[CFG_DATA_W-1:0];
    row.regs[tdor_pkg::REG_DIM_SIZE_3]     = s3[CFG_DATA_W-1:0];
    row.regs[tdor_pkg::REG_LOOPBACK_ON]    = lb[CFG_DATA_W-1:0];
    row.regs[tdor_pkg::REG_LIMITER_ON]     = lm[CFG_DATA_W-1:0];
    row.regs[tdor_pkg::REG_LINKS_PER_NODE] = lpn[CFG_DATA_W-1:0];
    queue_row(row);
  endfunction

  function automatic plan_row_t route_row(input int unsigned src, input int unsigned dst,
                                          input logic sr, input logic dr);
    plan_row_t row;
    row = '0;
    row.req.src_node   = src[NODE_W-1:0];
    row.req.dst_node   = dst[NODE_W-1:0];
    row.req.src_router = sr;
    row.req.dst_router = dr;
    return row;
  endfunction

  function automatic void add_route(input int unsigned src, input int unsigned dst);
    queue_row(route_row(src, dst, 1'b0, 1'b0));
  endfunction

  // Request known to give no entries at all.
  function automatic void add_silent(input int unsigned src, input int unsigned dst,
                                     input logic sr, input logic dr);
    plan_row_t row;
    row = route_row(src, dst, sr, dr);
    row.typed = 1'b1;
    queue_row(row);
  endfunction

  // Loopback request with its single entry written out.
  function automatic void add_loopback(input int unsigned node, input int unsigned link);
    plan_row_t row;
    row = route_row(node, node, 1'b0, 1'b0);
    row.typed     = 1'b1;
    row.typed_hit = 1'b1;
    row.typed_hop = '{link_index: link[LINK_W-1:0], use_up: 1'b1, limiter_entry: 1'b0,
                      hop_node: node[NODE_W-1:0], last: 1'b1};
    queue_row(row);
  endfunction

  function automatic logic [7:0][CFG_DATA_W-1:0] random_setup();
    logic [7:0][CFG_DATA_W-1:0] r;
    int unsigned v;
    v = ($urandom_range(7) == 0) ? $urandom_range(7) : $urandom_range(1, 4);
    v = v + 8 * $urandom_range(3);
    r[tdor_pkg::REG_NUM_DIMS] = v[CFG_DATA_W-1:0];
    for (int i = 0; i < NUM_SIZE_REGS; i++) begin
      v = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(2, MAX_DIM_SIZE_DEF);
      r[tdor_pkg::REG_DIM_SIZE_0 + i] = v[CFG_DATA_W-1:0];
    end
    v = $urandom();
    r[tdor_pkg::REG_LOOPBACK_ON] = v[CFG_DATA_W-1:0];
    v = $urandom();
    r[tdor_pkg::REG_LIMITER_ON] = v[CFG_DATA_W-1:0];
    v = $urandom_range(7) + 8 * $urandom_range(3);
    r[tdor_pkg::REG_LINKS_PER_NODE] = v[CFG_DATA_W-1:0];
    return r;
  endfunction

  // Mostly real routes: same node, near neighbors or anywhere, with a few router requests.
  function automatic route_req_t random_route();
    route_req_t rq;
    int unsigned pick, a, b;
    pick = $urandom_range(99);
    a = $urandom();
    b = $urandom();
    rq.src_node = a[NODE_W-1:0];
    if (pick < 12) begin
      rq.dst_node = a[NODE_W-1:0];
    end else if (pick < 45) begin
      b = a + $urandom_range(1, 300);
      rq.dst_node = b[NODE_W-1:0];
    end else begin
      rq.dst_node = b[NODE_W-1:0];
    end
    pick = $urandom_range(99);
    rq.src_router = (pick < 7);
    rq.dst_router = (pick >= 93);
    return rq;
  endfunction

  // Write every register in turn and keep the predictor's copy in step.
  task automatic program_regs(input logic [7:0][CFG_DATA_W-1:0] regs);
    logic [CFG_IDX_W-1:0] idx;
    for (int i = 0; i < 8; i++) begin
      idx = i[CFG_IDX_W-1:0];
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= regs[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        tdor_pkg::REG_NUM_DIMS:       torus_dims  = regs[i][NDIM_W-1:0];
        tdor_pkg::REG_DIM_SIZE_0:     torus_size[0] = regs[i];
        tdor_pkg::REG_DIM_SIZE_1:     torus_size[1] = regs[i];
        tdor_pkg::REG_DIM_SIZE_2:     torus_size[2] = regs[i];
        tdor_pkg::REG_DIM_SIZE_3:     torus_size[3] = regs[i];
        tdor_pkg::REG_LOOPBACK_ON:    loop_on     = regs[i][0];
        tdor_pkg::REG_LIMITER_ON:     lim_on      = regs[i][0];
        tdor_pkg::REG_LINKS_PER_NODE: link_stride = regs[i][LPN_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Offer one request, with a random gap first, and return once it is taken.
  task automatic send_route(input route_req_t rq);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rq.dst_node, rq.src_node};
    s_tuser  <= {rq.dst_router, rq.src_router};
    do @(posedge clk); while (!s_tready);
  endtask

  // Let every expected entry arrive and the block finish any silent request.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_hops.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: random back-pressure and in-order checking.
  always @(posedge clk) begin
    hop_entry_t want;
    m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_hops.size() == 0) begin
        $error("unexpected link entry: link_index %0d, hop_node %0d",
               m_tdata[LINK_W-1:0], m_tdata[LINK_W+NODE_W-1:LINK_W]);
        mismatches++;
      end else begin
        want = pending_hops.pop_front();
        check_field("link_index", want.link_index, m_tdata[LINK_W-1:0]);
        check_field("use_up", want.use_up, m_tuser[0]);
        check_field("limiter_entry", want.limiter_entry, m_tuser[1]);
        check_field("hop_node", want.hop_node, m_tdata[LINK_W+NODE_W-1:LINK_W]);
        check_field("last", want.last, m_tlast);
      end
    end
  end

  // Watchdog on cycles with no handshake of any kind.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("torus_dimension_order_router_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    plan_row_t  row;
    route_req_t rq;

    // Reset values: every dimension has size one, so only a loopback could answer.
    add_silent(0, 0, 1'b0, 1'b0);
    add_silent(1234, 4321, 1'b0, 1'b0);
    add_silent(65535, 65535, 1'b1, 1'b1);
    // Loopback with the widest node stride, and router requests on the same node.
    add_setup(1, 1, 1, 1, 1, 1, 0, 7);
    add_loopback(65535, 458745);
    add_loopback(0, 0);
    add_silent(5, 5, 1'b1, 1'b0);
    add_silent(5, 5, 1'b0, 1'b1);
    // Full four-dimensional torus with limiter entries: wrap hops and longest routes both ways.
    add_setup(4, 16, 16, 16, 16, 1, 1, 6);
    add_route(16'h0000, 16'hFFFF);
    add_route(16'h8888, 16'h0000);
    add_route(16'h1111, 16'h9999);
    add_route(16'hFFFF, 16'h0000);
    add_loopback(16'h1234, 27960);
    // Registers out of range, zero node stride, no loopback.
    add_setup(7, 31, 0, 3, 17, 0, 0, 0);
    add_route(0, 65535);
    add_route(65535, 65534);
    add_silent(1000, 1768, 1'b0, 1'b0);
    add_silent(7, 7, 1'b0, 1'b0);
    // Zero dimensions, smallest real ring.
    add_setup(0, 2, 1, 1, 1, 1, 1, 7);
    add_route(0, 1);
    add_route(1, 0);
    add_route(65535, 65534);
    add_route(65534, 65535);
    // Ring of three at the top of the rank space: the hop node runs past 16 bits.
    add_setup(1, 3, 1, 1, 1, 1, 1, 7);
    add_route(65535, 65534);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      row = plan[k];
      if (row.setup) begin
        settle();
        program_regs(row.regs);
      end else begin
        send_route(row.req);
        if (!row.typed) predict_route(row.req);
        else if (row.typed_hit) queue_hop(row.typed_hop);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      program_regs(random_setup());
      calm = (p == CALM_PHASE);
      for (int n = 0; n < ROUTES_PER_PHASE; n++) begin
        rq = random_route();
        send_route(rq);
        predict_route(rq);
      end
    end
    calm = 1'b0;

    settle();
    if (mismatches == 0) begin
      $display("torus_dimension_order_router_unit verification clean");
    end else begin
      $display("torus_dimension_order_router_unit verification failed");
    end
    $finish;
  end

endmodule
